FILE: rtl/uvst_pkg.sv
// uvst_pkg: shared codes and field widths for the unique value set table
// no dependencies; used by unique_value_set_table_unit
`default_nettype none

package uvst_pkg;

  // request action codes
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // field widths of the request and result channels
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;

endpackage

`default_nettype wire

FILE: rtl/uvst_ram.sv
// uvst_ram: generic single write port, single read port ram with registered read
// no dependencies; instanced by unique_value_set_table_unit
`default_nettype none

module uvst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/unique_value_set_table_unit.sv
// unique_value_set_table_unit: ordered set of distinct values with lookup, insert, remove
// a search reads the cells in order from the lowest; an insert on a miss writes at its end;
//   a remove on a hit then compacts the later cells; then the result register is loaded
// throughput: one request at a time; the ram read port and its one comparator set the pace
// reset (rst, synchronous): table empty, no result pending; cell contents stay as they are
`default_nettype none

module unique_value_set_table_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // request channel
  input  wire logic                                cmd_valid,
  output logic                                     cmd_stall,
  input  wire logic [1:0]                          action,
  input  wire logic signed [uvst_pkg::ValueW-1:0]  value,
  // result channel
  output logic                                     res_valid,
  input  wire logic                                res_stall,
  output logic                                     found,
  output logic [uvst_pkg::PosW-1:0]                position,
  output logic [uvst_pkg::CountW-1:0]              entry_count,
  output logic                                     full_drop
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = uvst_pkg::ValueW;
  localparam int unsigned PW = uvst_pkg::PosW;
  localparam int unsigned NW = uvst_pkg::CountW;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SRCH  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t          state, state_next;
  logic [1:0]      act, act_next;
  logic [VW-1:0]   val, val_next;
  logic [CW-1:0]   idx, idx_next;
  logic [CW-1:0]   count, count_next;
  logic            cmp_pend, cmp_pend_next;
  logic [AW-1:0]   cmp_idx, cmp_idx_next;
  logic            sh_pend, sh_pend_next;
  logic [AW-1:0]   sh_dst, sh_dst_next;
  logic            hit, hit_next;
  logic [AW-1:0]   pos, pos_next;
  logic            drop, drop_next;
  logic            res_valid_next;
  logic            found_next;
  logic [PW-1:0]   position_next;
  logic [NW-1:0]   entry_count_next;
  logic            full_drop_next;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [VW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [VW-1:0]   ram_rdata;

  logic            cmd_accept;
  logic            match;
  logic            hit_now;
  logic [AW-1:0]   pos_now;
  logic [AW+PW-1:0] pos_wide;
  logic [CW+NW-1:0] cnt_wide;

  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign match      = cmp_pend && (ram_rdata == val);
  assign pos_wide   = {{PW{1'b0}}, pos};
  assign cnt_wide   = {{NW{1'b0}}, count};

  // table storage
  uvst_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer: search, then insert or compaction, then result load
  always_comb begin
    state_next       = state;
    act_next         = act;
    val_next         = val;
    idx_next         = idx;
    count_next       = count;
    cmp_pend_next    = cmp_pend;
    cmp_idx_next     = cmp_idx;
    sh_pend_next     = sh_pend;
    sh_dst_next      = sh_dst;
    hit_next         = hit;
    pos_next         = pos;
    drop_next        = drop;
    res_valid_next   = res_valid && res_stall;
    found_next       = found;
    position_next    = position;
    entry_count_next = entry_count;
    full_drop_next   = full_drop;
    ram_we           = 1'b0;
    ram_waddr        = sh_dst;
    ram_wdata        = ram_rdata;
    ram_raddr        = idx[AW-1:0];
    hit_now          = 1'b0;
    pos_now          = '0;

    case (state)
      S_IDLE: begin
        if (cmd_accept) begin
          act_next      = action;
          val_next      = value;
          idx_next      = '0;
          cmp_pend_next = 1'b0;
          drop_next     = 1'b0;
          state_next    = S_SRCH;
        end
      end

      S_SRCH: begin
        if (match || (idx == count)) begin
          // search finished: lowest matching cell or a miss
          hit_now       = match;
          pos_now       = match ? cmp_idx : '0;
          hit_next      = hit_now;
          pos_next      = pos_now;
          cmp_pend_next = 1'b0;
          state_next    = S_DONE;
          if ((act == uvst_pkg::ACT_REMOVE) && hit_now) begin
            idx_next     = CW'(pos_now) + CW'(1);
            sh_pend_next = 1'b0;
            state_next   = S_SHIFT;
          end else if ((act == uvst_pkg::ACT_INSERT) && !hit_now) begin
            if (count < DepthC) begin
              ram_we     = 1'b1;
              ram_waddr  = count[AW-1:0];
              ram_wdata  = val;
              count_next = count + CW'(1);
            end else begin
              drop_next  = 1'b1;
            end
          end
        end else begin
          // read next cell, compare it in the cycle after
          cmp_idx_next  = idx[AW-1:0];
          idx_next      = idx + CW'(1);
          cmp_pend_next = 1'b1;
        end
      end

      S_SHIFT: begin
        // move cell idx-1 into idx-2 while reading the next one
        ram_we = sh_pend;
        if (idx < count) begin
          sh_pend_next = 1'b1;
          sh_dst_next  = AW'(idx - CW'(1));
          idx_next     = idx + CW'(1);
        end else begin
          sh_pend_next = 1'b0;
          count_next   = count - CW'(1);
          state_next   = S_DONE;
        end
      end

      S_DONE: begin
        if (!res_valid || !res_stall) begin
          res_valid_next   = 1'b1;
          found_next       = hit;
          position_next    = pos_wide[PW-1:0];
          entry_count_next = cnt_wide[NW-1:0];
          full_drop_next   = drop;
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_pend  <= 1'b0;
      sh_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_pend  <= cmp_pend_next;
      sh_pend   <= sh_pend_next;
      res_valid <= res_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    act         <= act_next;
    val         <= val_next;
    idx         <= idx_next;
    cmp_idx     <= cmp_idx_next;
    sh_dst      <= sh_dst_next;
    hit         <= hit_next;
    pos         <= pos_next;
    drop        <= drop_next;
    found       <= found_next;
    position    <= position_next;
    entry_count <= entry_count_next;
    full_drop   <= full_drop_next;
  end

`ifndef SYNTHESIS
  // fill level never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DepthC)
    else $error("entry count above depth");

  // a dropped insert is always a miss
  a_drop_miss: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(full_drop && found))
    else $error("drop flagged on a hit");

  // an accepted request closes the request side on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_accept |=> cmd_stall)
    else $error("request side open while busy");

  // the table is only written by the search end or compaction
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_SRCH) || (state == S_SHIFT)))
    else $error("ram write outside search or shift");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/uvst_checker.sv
// uvst_checker: watches the request and result channels of the value set table,
// predicts each result from its own copy of the table and compares field by field
// depends on uvst_pkg for the action codes and field widths
`timescale 1ns / 1ps

module uvst_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cmd_valid,
  input  wire logic                         cmd_stall,
  input  wire logic [1:0]                   action,
  input  wire logic signed [uvst_pkg::ValueW-1:0] value,
  input  wire logic                         res_valid,
  input  wire logic                         res_stall,
  input  wire logic                         found,
  input  wire logic [uvst_pkg::PosW-1:0]    position,
  input  wire logic [uvst_pkg::CountW-1:0]  entry_count,
  input  wire logic                         full_drop,
  output int unsigned                       n_pending,
  output int unsigned                       n_fail,
  output int unsigned                       n_checked,
  output int unsigned                       n_hits,
  output int unsigned                       n_drops
);

  typedef struct packed {
    logic                        found;
    logic [uvst_pkg::PosW-1:0]   position;
    logic [uvst_pkg::CountW-1:0] entry_count;
    logic                        full_drop;
  } set_result_t;

  // shadow copy of the table
  logic signed [uvst_pkg::ValueW-1:0] shadow_cells [DEPTH];
  int unsigned                        shadow_count = 0;
  set_result_t                        expected_results [$];

  initial begin
    n_pending = 0;
    n_fail    = 0;
    n_checked = 0;
    n_hits    = 0;
    n_drops   = 0;
  end

  // apply one request to the shadow table and return the result it should give
  function automatic set_result_t apply_request(logic [1:0] act,
                                                logic signed [uvst_pkg::ValueW-1:0] val);
    set_result_t r;
    logic        hit;
    int unsigned where;
    logic        drop;
    hit   = 1'b0;
    where = 0;
    drop  = 1'b0;
    // lowest matching valid cell
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (!hit && shadow_cells[i] == val) begin
        hit   = 1'b1;
        where = i;
      end
    end
    case (act)
      uvst_pkg::ACT_INSERT: begin
        if (!hit) begin
          if (shadow_count < DEPTH) begin
            shadow_cells[shadow_count] = val;
            shadow_count++;
          end else begin
            drop = 1'b1;
          end
        end
      end
      uvst_pkg::ACT_REMOVE: begin
        // compact the later cells down one place
        if (hit) begin
          for (int unsigned i = where; i + 1 < shadow_count; i++) begin
            shadow_cells[i] = shadow_cells[i + 1];
          end
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    r.found       = hit;
    r.position    = where[uvst_pkg::PosW-1:0];
    r.entry_count = shadow_count[uvst_pkg::CountW-1:0];
    r.full_drop   = drop;
    return r;
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    set_result_t want;
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        want = apply_request(action, value);
        if (want.found) n_hits++;
        if (want.full_drop) n_drops++;
        expected_results.push_back(want);
      end
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request pending: found %0d position %0d count %0d drop %0d",
                 found, position, entry_count, full_drop);
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            n_fail++;
          end
          if (position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, position);
            n_fail++;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
            n_fail++;
          end
          if (full_drop !== want.full_drop) begin
            $error("full_drop: expected %0d, actual %0d", want.full_drop, full_drop);
            n_fail++;
          end
        end
      end
      n_pending = expected_results.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: stimulus, clock, reset and verdict for unique_value_set_table_unit
// depends on uvst_pkg, the block and uvst_checker
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam logic [1:0]  ACT_SPARE    = 2'd3;
  localparam int unsigned N_PHASES     = 6;
  localparam int unsigned PHASE_ITEMS  = 250;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 64;

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               cmd_valid = 1'b0;
  logic                               cmd_stall;
  logic [1:0]                         action    = uvst_pkg::ACT_LOOKUP;
  logic signed [uvst_pkg::ValueW-1:0] value     = '0;
  logic                               res_valid;
  logic                               res_stall = 1'b0;
  logic                               found;
  logic [uvst_pkg::PosW-1:0]          position;
  logic [uvst_pkg::CountW-1:0]        entry_count;
  logic                               full_drop;

  int unsigned n_pending, n_fail, n_checked, n_hits, n_drops;

  // idling control shared by both sides
  bit          idle_on    = 1'b0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen  = 0;
  int unsigned rx_hold    = 0;
  int unsigned n_sent     = 0;

  logic signed [uvst_pkg::ValueW-1:0] value_pool [POOL_SIZE];

  always #2 clk = ~clk;

  unique_value_set_table_unit #(.DEPTH(TABLE_DEPTH)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .action      (action),
    .value       (value),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .found       (found),
    .position    (position),
    .entry_count (entry_count),
    .full_drop   (full_drop)
  );

  uvst_checker #(.DEPTH(TABLE_DEPTH)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .action      (action),
    .value       (value),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .found       (found),
    .position    (position),
    .entry_count (entry_count),
    .full_drop   (full_drop),
    .n_pending   (n_pending),
    .n_fail      (n_fail),
    .n_checked   (n_checked),
    .n_hits      (n_hits),
    .n_drops     (n_drops)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // action mix per phase: fill-heavy, drain-heavy, balanced
  function automatic logic [1:0] pick_action(int unsigned phase);
    int unsigned r;
    int unsigned ins_pct;
    int unsigned rem_pct;
    r = $urandom_range(0, 99);
    case (phase % 3)
      0:       begin ins_pct = 55; rem_pct = 15; end
      1:       begin ins_pct = 20; rem_pct = 50; end
      default: begin ins_pct = 35; rem_pct = 30; end
    endcase
    if (r < 5) return ACT_SPARE;
    if (r < 5 + ins_pct) return uvst_pkg::ACT_INSERT;
    if (r < 5 + ins_pct + rem_pct) return uvst_pkg::ACT_REMOVE;
    return uvst_pkg::ACT_LOOKUP;
  endfunction

  // values mostly from a small pool so that hits and a full table happen
  function automatic logic signed [uvst_pkg::ValueW-1:0] pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // offer one request, hold it until accepted, then optionally go idle
  task automatic offer_request(logic [1:0] act, logic signed [uvst_pkg::ValueW-1:0] val,
                               int unsigned gap);
    cmd_valid <= 1'b1;
    action    <= act;
    value     <= val;
    do @(posedge clk); while (cmd_stall);
    n_sent++;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // pause the sender until every result is back
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    // let the checker log the last accepted request first
    @(posedge clk);
    wait (n_pending == 0);
    @(posedge clk);
  endtask

  // result side stall: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      rx_hold   = LONG_HOLD;
    end
    if (rx_hold != 0) begin
      res_stall <= 1'b1;
      rx_hold--;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      res_stall <= 1'b1;
      rx_hold   = pick_gap();
    end else begin
      res_stall <= 1'b0;
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus and verdict
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every action, duplicates, full table, compaction
    offer_request(uvst_pkg::ACT_LOOKUP, 32'sd7, 0);
    offer_request(uvst_pkg::ACT_INSERT, 32'h8000_0000, 0);
    offer_request(uvst_pkg::ACT_INSERT, 32'h7fff_ffff, 0);
    offer_request(uvst_pkg::ACT_INSERT, 32'sd0, 0);
    offer_request(uvst_pkg::ACT_INSERT, -32'sd1, 0);
    offer_request(uvst_pkg::ACT_INSERT, 32'h7fff_ffff, 0);
    offer_request(uvst_pkg::ACT_LOOKUP, -32'sd1, 0);
    offer_request(ACT_SPARE, 32'sd0, 0);
    offer_request(uvst_pkg::ACT_REMOVE, 32'sd5, 0);
    for (int i = 0; i < 12; i++) begin
      offer_request(uvst_pkg::ACT_INSERT, 32'sd100 + i, 0);
    end
    offer_request(uvst_pkg::ACT_INSERT, 32'sd999, 0);
    offer_request(uvst_pkg::ACT_INSERT, 32'sd0, 0);
    offer_request(uvst_pkg::ACT_REMOVE, 32'h8000_0000, 0);
    offer_request(uvst_pkg::ACT_REMOVE, 32'sd111, 0);
    offer_request(uvst_pkg::ACT_REMOVE, 32'sd104, 0);
    wait_drained();

    // random pool with the extremes in it
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) begin
      value_pool[i] = $urandom;
    end

    // random phases, the first without idling
    for (int unsigned phase = 0; phase < N_PHASES; phase++) begin
      idle_on = (phase != 0);
      if (phase == 2 || phase == 4) hold_asked++;
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        offer_request(pick_action(phase), pick_value(), idle_on ? pick_gap() : 0);
      end
      wait_drained();
    end

    idle_on = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: lookups, inserts, removes and the spare action", n_sent);
    $display("checked %0d results, %0d hits, %0d inserts dropped on a full table",
             n_checked, n_hits, n_drops);
    if (n_fail == 0 && n_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: unique_value_set_table_unit.f
rtl/uvst_pkg.sv
rtl/uvst_ram.sv
rtl/unique_value_set_table_unit.sv
tb/sv/uvst_checker.sv
tb/sv/tb_top.sv
